@@ rtl/xcfd_pkg.sv @@
package xcfd_pkg;

   localparam logic [7:0] CSR_RESET_VALUE = 8'h4A;

   localparam int unsigned CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SYNC_BYTE     = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHECKSUM_SEED = 1'b1;

   localparam logic REQ_LINE_BYTE = 1'b0;
   localparam logic REQ_READ      = 1'b1;

   localparam logic RSP_FRAME = 1'b0;
   localparam logic RSP_READ  = 1'b1;

   localparam int unsigned OP_DEPTH  = 4;
   localparam int unsigned OP_PTR_W  = $clog2(OP_DEPTH);
   localparam int unsigned OP_CNT_W  = $clog2(OP_DEPTH + 1);
   localparam int unsigned OUT_DEPTH = 4;
   localparam int unsigned OUT_PTR_W = $clog2(OUT_DEPTH);
   localparam int unsigned OUT_CNT_W = $clog2(OUT_DEPTH + 1);

   typedef enum logic [2:0] {
      PH_WAIT    = 3'd0,
      PH_FN_HI   = 3'd1,
      PH_FN_LO   = 3'd2,
      PH_LEN_HI  = 3'd3,
      PH_LEN_LO  = 3'd4,
      PH_PAYLOAD = 3'd5,
      PH_CHECK   = 3'd6
   } phase_type;

   typedef enum logic [1:0] {
      OP_WRITE  = 2'd0,
      OP_READ   = 2'd1,
      OP_REPORT = 2'd2
   } op_kind_type;

   typedef struct packed {
      logic       req_type;
      logic [7:0] line_byte;
      logic [7:0] read_index;
   } req_item_type;

   typedef struct packed {
      logic        result_kind;
      logic [15:0] function_code;
      logic [15:0] frame_length;
      logic        checksum_good;
      logic        payload_truncated;
      logic [7:0]  read_data;
   } rsp_item_type;

   // one unit of work handed from parser to executor
   typedef struct packed {
      op_kind_type kind;
      logic [15:0] addr;
      logic [7:0]  wdata;
      logic        read_zero;
      logic [15:0] function_code;
      logic [15:0] frame_length;
      logic        checksum_good;
      logic        payload_truncated;
   } op_item_type;

endpackage

@@ rtl/xcfd_ram.sv @@
module xcfd_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 256
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/xcfd_front.sv @@
module xcfd_front #(
   parameter int unsigned PAYLOAD_DEPTH = 256
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 push,
   input  logic                                 full,
   input  xcfd_pkg::req_item_type               req_item,
   input  logic                                 csr_valid,
   input  logic [xcfd_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [7:0]                           csr_data,
   output logic                                 op_valid,
   output xcfd_pkg::op_item_type                op
);

   logic [7:0]          sync_byte_ff;
   logic [7:0]          seed_ff;
   xcfd_pkg::phase_type phase_ff, phase_in;
   logic [15:0]         func_ff, func_in;
   logic [15:0]         len_ff, len_in;
   logic [15:0]         seen_ff, seen_in;
   logic [7:0]          xor_ff, xor_in;
   logic                accept;
   logic [7:0]          b;

   assign accept = push && !full;
   assign b      = req_item.line_byte;

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_byte_ff <= xcfd_pkg::CSR_RESET_VALUE;
         seed_ff      <= xcfd_pkg::CSR_RESET_VALUE;
      end else if (csr_valid) begin
         unique case (csr_index)
            xcfd_pkg::CSR_SYNC_BYTE:     sync_byte_ff <= csr_data;
            xcfd_pkg::CSR_CHECKSUM_SEED: seed_ff      <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= xcfd_pkg::PH_WAIT;
         func_ff  <= '0;
         len_ff   <= '0;
         seen_ff  <= '0;
         xor_ff   <= xcfd_pkg::CSR_RESET_VALUE;
      end else begin
         phase_ff <= phase_in;
         func_ff  <= func_in;
         len_ff   <= len_in;
         seen_ff  <= seen_in;
         xor_ff   <= xor_in;
      end
   end

   always_comb begin
      phase_in = phase_ff;
      func_in  = func_ff;
      len_in   = len_ff;
      seen_in  = seen_ff;
      xor_in   = xor_ff;
      op_valid = 1'b0;
      op       = '0;
      op.kind  = xcfd_pkg::OP_WRITE;

      if (accept) begin
         if (req_item.req_type == xcfd_pkg::REQ_READ) begin
            // reads bypass the parser entirely
            op_valid     = 1'b1;
            op.kind      = xcfd_pkg::OP_READ;
            op.addr      = {8'b0, req_item.read_index};
            op.read_zero = ({9'b0, req_item.read_index} >= 17'(PAYLOAD_DEPTH));
         end else begin
            unique case (phase_ff)
               xcfd_pkg::PH_FN_HI: begin
                  func_in  = {b, 8'b0};
                  xor_in   = xor_ff ^ b;
                  phase_in = xcfd_pkg::PH_FN_LO;
               end
               xcfd_pkg::PH_FN_LO: begin
                  func_in  = {func_ff[15:8], b};
                  xor_in   = xor_ff ^ b;
                  phase_in = xcfd_pkg::PH_LEN_HI;
               end
               xcfd_pkg::PH_LEN_HI: begin
                  len_in   = {b, 8'b0};
                  xor_in   = xor_ff ^ b;
                  phase_in = xcfd_pkg::PH_LEN_LO;
               end
               xcfd_pkg::PH_LEN_LO: begin
                  len_in   = {len_ff[15:8], b};
                  xor_in   = xor_ff ^ b;
                  seen_in  = '0;
                  phase_in = (len_in != 16'd0) ? xcfd_pkg::PH_PAYLOAD
                                               : xcfd_pkg::PH_CHECK;
               end
               xcfd_pkg::PH_PAYLOAD: begin
                  // bytes past the store are still counted and checksummed
                  if ({1'b0, seen_ff} < 17'(PAYLOAD_DEPTH)) begin
                     op_valid = 1'b1;
                     op.kind  = xcfd_pkg::OP_WRITE;
                     op.addr  = seen_ff;
                     op.wdata = b;
                  end
                  xor_in  = xor_ff ^ b;
                  seen_in = seen_ff + 16'd1;
                  if (seen_in >= len_ff) begin
                     phase_in = xcfd_pkg::PH_CHECK;
                  end
               end
               xcfd_pkg::PH_CHECK: begin
                  op_valid             = 1'b1;
                  op.kind              = xcfd_pkg::OP_REPORT;
                  op.function_code     = func_ff;
                  op.frame_length      = len_ff;
                  op.checksum_good     = (xor_ff == b);
                  op.payload_truncated = ({1'b0, len_ff} > 17'(PAYLOAD_DEPTH));
                  phase_in             = xcfd_pkg::PH_WAIT;
               end
               default: begin
                  if (b == sync_byte_ff) begin
                     xor_in   = seed_ff;
                     phase_in = xcfd_pkg::PH_FN_HI;
                  end else begin
                     phase_in = xcfd_pkg::PH_WAIT;
                  end
               end
            endcase
         end
      end
   end

endmodule

@@ rtl/xcfd_op_queue.sv @@
module xcfd_op_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_en,
   input  xcfd_pkg::op_item_type push_op,
   output logic                  full,
   output logic                  head_valid,
   output xcfd_pkg::op_item_type head_op,
   input  logic                  pop_en
);

   xcfd_pkg::op_item_type             slot_ff [xcfd_pkg::OP_DEPTH];
   logic [xcfd_pkg::OP_PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [xcfd_pkg::OP_PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [xcfd_pkg::OP_CNT_W-1:0]     count_ff, count_in;
   logic                              do_push;
   logic                              do_pop;

   assign full       = (count_ff == xcfd_pkg::OP_CNT_W'(xcfd_pkg::OP_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_op    = slot_ff[rd_ptr_ff];
   assign do_push    = push_en && !full;
   assign do_pop     = pop_en && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == xcfd_pkg::OP_PTR_W'(xcfd_pkg::OP_DEPTH - 1))
                     ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == xcfd_pkg::OP_PTR_W'(xcfd_pkg::OP_DEPTH - 1))
                     ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

@@ rtl/xcfd_back.sv @@
module xcfd_back #(
   parameter int unsigned PAYLOAD_DEPTH = 256
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   head_valid,
   input  xcfd_pkg::op_item_type  head_op,
   output logic                   pop_en,
   output logic                   empty,
   input  logic                   pop,
   output xcfd_pkg::rsp_item_type rsp_item
);

   localparam int unsigned ADDR_W = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
   localparam int unsigned CRED_W = xcfd_pkg::OUT_CNT_W + 1;

   // stage 1: store access in flight
   logic                   s1_valid_ff;
   logic                   s1_read_ff;
   logic                   s1_zero_ff;
   xcfd_pkg::rsp_item_type s1_rsp_ff;

   xcfd_pkg::rsp_item_type out_slot_ff [xcfd_pkg::OUT_DEPTH];
   logic [xcfd_pkg::OUT_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [xcfd_pkg::OUT_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [xcfd_pkg::OUT_CNT_W-1:0] count_ff, count_in;

   logic                   is_write;
   logic                   credit;
   logic                   issue;
   logic [7:0]             ram_rdata;
   xcfd_pkg::rsp_item_type s2_rsp;
   logic                   do_pop;

   assign is_write = (head_op.kind == xcfd_pkg::OP_WRITE);
   // results already queued plus the one in flight must leave room
   assign credit   = (CRED_W'(count_ff) + CRED_W'(s1_valid_ff))
                     < CRED_W'(xcfd_pkg::OUT_DEPTH);
   assign issue    = head_valid && (is_write || credit);
   assign pop_en   = issue;

   xcfd_ram #(
      .WIDTH (8),
      .DEPTH (PAYLOAD_DEPTH)
   ) u_payload_ram (
      .clock   (clock),
      .wr_en   (issue && is_write),
      .wr_addr (head_op.addr[ADDR_W-1:0]),
      .wr_data (head_op.wdata),
      .rd_en   (issue && (head_op.kind == xcfd_pkg::OP_READ)),
      .rd_addr (head_op.addr[ADDR_W-1:0]),
      .rd_data (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= issue && !is_write;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         s1_read_ff                  <= (head_op.kind == xcfd_pkg::OP_READ);
         s1_zero_ff                  <= head_op.read_zero;
         s1_rsp_ff.result_kind       <= (head_op.kind == xcfd_pkg::OP_READ)
                                        ? xcfd_pkg::RSP_READ : xcfd_pkg::RSP_FRAME;
         s1_rsp_ff.function_code     <= head_op.function_code;
         s1_rsp_ff.frame_length      <= head_op.frame_length;
         s1_rsp_ff.checksum_good     <= head_op.checksum_good;
         s1_rsp_ff.payload_truncated <= head_op.payload_truncated;
         s1_rsp_ff.read_data         <= '0;
      end
   end

   always_comb begin
      s2_rsp = s1_rsp_ff;
      if (s1_read_ff && !s1_zero_ff) begin
         s2_rsp.read_data = ram_rdata;
      end
   end

   assign empty    = (count_ff == '0);
   assign rsp_item = out_slot_ff[rd_ptr_ff];
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (s1_valid_ff) begin
         wr_ptr_in = (wr_ptr_ff == xcfd_pkg::OUT_PTR_W'(xcfd_pkg::OUT_DEPTH - 1))
                     ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == xcfd_pkg::OUT_PTR_W'(xcfd_pkg::OUT_DEPTH - 1))
                     ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({s1_valid_ff, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         out_slot_ff[wr_ptr_ff] <= s2_rsp;
      end
   end

endmodule

@@ rtl/xor_checked_frame_deframer_top.sv @@
// Frame deframer: hunts for the sync byte, then takes function (16 bit, big
// endian), length (16 bit), length payload bytes and an XOR checksum byte.
// Request channel (push/full, req_item): a line byte or a read of a stored
// payload byte. One request is taken per cycle while full is low.
// Response channel (empty/pop, rsp_item): a frame report on each checksum
// byte, or the data for a read. Line bytes that end no frame give nothing.
// The parser works on each request as it arrives and posts store writes,
// reads and reports into a four-entry operation queue; the executor drains
// it at one operation a cycle, reads and reports only while the response
// queue has room, through the payload RAM into a four-entry response queue.
// A response passes the operation queue, store stage and response queue.
// When pop is held low the response queue fills, the executor stops issuing
// result operations and the operation queue then raises full.
// CSR writes (csr_valid, always ready) set the sync byte (index 0) and the
// checksum seed (index 1); both reset to 0x4A. Reset returns the parser to
// sync hunt and empties both queues; payload RAM contents are not cleared.
module xor_checked_frame_deframer_top #(
   parameter int unsigned PAYLOAD_DEPTH = 256
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             push,
   output logic                             full,
   input  xcfd_pkg::req_item_type           req_item,
   output logic                             empty,
   input  logic                             pop,
   output xcfd_pkg::rsp_item_type           rsp_item,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [xcfd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]                       csr_data
);

   logic                  op_valid;
   xcfd_pkg::op_item_type op;
   logic                  head_valid;
   xcfd_pkg::op_item_type head_op;
   logic                  pop_en;

   assign csr_ready = 1'b1;

   xcfd_front #(
      .PAYLOAD_DEPTH (PAYLOAD_DEPTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_item  (req_item),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .op_valid  (op_valid),
      .op        (op)
   );

   xcfd_op_queue u_op_queue (
      .clock      (clock),
      .reset      (reset),
      .push_en    (op_valid),
      .push_op    (op),
      .full       (full),
      .head_valid (head_valid),
      .head_op    (head_op),
      .pop_en     (pop_en)
   );

   xcfd_back #(
      .PAYLOAD_DEPTH (PAYLOAD_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_op    (head_op),
      .pop_en     (pop_en),
      .empty      (empty),
      .pop        (pop),
      .rsp_item   (rsp_item)
   );

endmodule
